// ----- hdl/hprle_pkg.sv -----
// Shared constants, codes and result record type for the heading path run-length encoder.
package hprle_pkg;

  localparam int unsigned MaxMoves     = 64;
  localparam int unsigned MaxPathCells = 255;
  localparam int unsigned MaxResults   = 4;

  localparam int unsigned HeadingW = 3;
  localparam int unsigned HeadW    = 2;
  localparam int unsigned KindW    = 3;
  localparam int unsigned CellW    = 8;
  localparam int unsigned SpeedW   = 16;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned TurnsW   = 7;
  localparam int unsigned MovesW   = $clog2(MaxMoves + 1);
  localparam int unsigned CntW     = $clog2(MaxResults + 1);
  localparam int unsigned SlotW    = $clog2(MaxResults);
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [SpeedW-1:0] RunSpeedReset = SpeedW'(750);
  localparam logic [HeadW-1:0]  StartHeadReset = '0;

  typedef enum logic [KindW-1:0] {
    KindFwd   = 3'd0,
    KindRight = 3'd1,
    KindLeft  = 3'd2,
    KindUturn = 3'd3,
    KindDone  = 3'd4
  } move_kind_e;

  typedef enum logic [StatusW-1:0] {
    StatusOk       = 2'd0,
    StatusOverflow = 2'd1,
    StatusMismatch = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRunSpeed     = 1'b0,
    CfgStartHeading = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    move_kind_e        kind;
    logic [CellW-1:0]  cells;
    logic [SpeedW-1:0] speed;
    logic [IdxW-1:0]   idx;
    status_e           status;
    logic [TurnsW-1:0] turns;
  } move_t;

endpackage

// ----- hdl/heading_path_run_length_encoder.sv -----
// Top level of the heading path run-length encoder: path state, result buffer, output register.
//
// Takes one cell heading per transfer and emits motion commands: FORWARD(n) for a straight run,
// RIGHT, LEFT or UTURN on a change of heading, and DONE (with status and turn total) at the end
// of a path. An input transfer is taken in any cycle in which the four-entry result buffer is
// empty or hands its last entry to the output register; all of the item's work (run update,
// command list, move store overflow check, cell total check) happens in the accepting cycle and
// lands in that buffer. The output register takes one command per cycle while the output is not
// stalled, so the next item is taken once the buffer is down to its last entry. The first command
// of an item passes from the result buffer into the output register before it leaves the block.
// Items that give no command (straight headings, invalid headings, items of a failed path) leave
// the buffer empty. last_result_o marks the final command of each item. Configuration writes take
// effect at once; write them only while the block is idle. A new start heading applies from the
// next first-marked item, or from the item after the next path close.
module heading_path_run_length_encoder (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [hprle_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [hprle_pkg::CfgDataW-1:0]    cfg_data_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [hprle_pkg::HeadingW-1:0]    heading_i,
  input  logic                              first_of_path_i,
  input  logic                              last_of_path_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [hprle_pkg::KindW-1:0]       move_kind_o,
  output logic [hprle_pkg::CellW-1:0]       cell_count_o,
  output logic [hprle_pkg::SpeedW-1:0]      speed_o,
  output logic [hprle_pkg::IdxW-1:0]        move_index_o,
  output logic [hprle_pkg::StatusW-1:0]     status_o,
  output logic [hprle_pkg::TurnsW-1:0]      turn_total_o,
  output logic                              last_result_o
);
  import hprle_pkg::*;

  // Configuration registers
  logic [SpeedW-1:0] run_speed_q;
  logic [HeadW-1:0]  start_head_q;

  // Path state
  logic [HeadW-1:0]  head_q,   head_d;
  logic [CellW-1:0]  run_q,    run_d;
  logic [MovesW-1:0] moves_q,  moves_d;
  logic [CellW-1:0]  cells_q,  cells_d;
  logic [CellW-1:0]  items_q,  items_d;
  logic [TurnsW-1:0] turns_q,  turns_d;
  logic              failed_q, failed_d;

  // Result buffer (head entry at slot 0) and output register
  move_t             pend_q   [MaxResults];
  move_t             pend_d   [MaxResults];
  logic [CntW-1:0]   pend_cnt_q, pend_cnt_d;
  move_t             out_q,   out_d;
  logic              out_valid_q, out_valid_d;
  logic              out_last_q,  out_last_d;

  // Per-item command list
  move_t             list     [MaxResults];
  logic [CntW-1:0]   list_cnt;

  logic              in_xfer;
  logic              out_free;
  logic              pop;

  // Effective state after an optional path start
  logic [HeadW-1:0]  e_head;
  logic [CellW-1:0]  e_run;
  logic [MovesW-1:0] e_moves;
  logic [CellW-1:0]  e_cells;
  logic [CellW-1:0]  e_items;
  logic [TurnsW-1:0] e_turns;
  logic              e_failed;

  logic              head_ok;
  logic [HeadW-1:0]  new_head;
  logic              change;
  logic [HeadW-1:0]  diff;
  move_kind_e        turn_kind;
  logic [CellW-1:0]  run_mid;
  logic [CellW-1:0]  cells_fin;
  logic [CellW-1:0]  items_nx;
  status_e           done_status;
  logic              cand_en  [MaxResults];
  move_t             cand     [MaxResults];
  logic [MovesW-1:0] m;
  logic [TurnsW-1:0] t;
  logic              fail;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign pop        = out_free && (pend_cnt_q != '0);
  assign in_stall_o = !((pend_cnt_q == '0) ||
                        ((pend_cnt_q == CntW'(1)) && out_free));
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Build the command list for the offered item and the path state it leaves.
  always_comb begin
    if (first_of_path_i) begin
      e_head   = start_head_q;
      e_run    = '0;
      e_moves  = '0;
      e_cells  = '0;
      e_items  = '0;
      e_turns  = '0;
      e_failed = 1'b0;
    end else begin
      e_head   = head_q;
      e_run    = run_q;
      e_moves  = moves_q;
      e_cells  = cells_q;
      e_items  = items_q;
      e_turns  = turns_q;
      e_failed = failed_q;
    end

    head_ok  = !heading_i[HeadingW-1];
    new_head = heading_i[HeadW-1:0];
    change   = head_ok && (new_head != e_head);
    diff     = new_head - e_head;
    unique case (diff)
      2'd1:    turn_kind = KindRight;
      2'd3:    turn_kind = KindLeft;
      default: turn_kind = KindUturn;
    endcase

    if (change) begin
      run_mid = CellW'(1);
    end else if (head_ok) begin
      run_mid = e_run + CellW'(1);
    end else begin
      run_mid = e_run;
    end

    for (int k = 0; k < MaxResults; k++) begin
      cand[k] = '0;
    end
    cand_en[0]     = change && (e_run != '0);
    cand[0].kind   = KindFwd;
    cand[0].cells  = e_run;
    cand[0].speed  = run_speed_q;
    cand_en[1]     = change;
    cand[1].kind   = turn_kind;
    cand_en[2]     = last_of_path_i && (run_mid != '0);
    cand[2].kind   = KindFwd;
    cand[2].cells  = run_mid;
    cand[2].speed  = run_speed_q;
    cand_en[3]     = last_of_path_i;
    cand[3].kind   = KindDone;

    cells_fin   = e_cells + (cand_en[0] ? e_run : '0) + (cand_en[2] ? run_mid : '0);
    items_nx    = e_items + CellW'(1);
    done_status = (cells_fin != items_nx) ? StatusMismatch : StatusOk;
    cand[3].status = done_status;

    for (int k = 0; k < MaxResults; k++) begin
      list[k] = '0;
    end
    list_cnt = '0;
    m        = e_moves;
    t        = e_turns;
    fail     = 1'b0;

    if (!e_failed) begin
      if (e_items >= CellW'(MaxPathCells)) begin
        // Too many items: report overflow and drop the item.
        list[0].kind   = KindDone;
        list[0].idx    = e_moves[IdxW-1:0];
        list[0].status = StatusOverflow;
        list[0].turns  = e_turns;
        list_cnt       = CntW'(1);
        fail           = 1'b1;
      end else begin
        // Walk the candidates in order; a full move store ends the item.
        for (int k = 0; k < MaxResults; k++) begin
          if (cand_en[k] && !fail) begin
            if (m >= MovesW'(MaxMoves)) begin
              list[list_cnt[SlotW-1:0]].kind   = KindDone;
              list[list_cnt[SlotW-1:0]].cells  = '0;
              list[list_cnt[SlotW-1:0]].speed  = '0;
              list[list_cnt[SlotW-1:0]].idx    = m[IdxW-1:0];
              list[list_cnt[SlotW-1:0]].status = StatusOverflow;
              list[list_cnt[SlotW-1:0]].turns  = t;
              fail = 1'b1;
            end else begin
              list[list_cnt[SlotW-1:0]]       = cand[k];
              list[list_cnt[SlotW-1:0]].idx   = m[IdxW-1:0];
              list[list_cnt[SlotW-1:0]].turns = (k == MaxResults - 1) ? t : '0;
              m = m + MovesW'(1);
              if (k == 1) begin
                t = t + TurnsW'(1);
              end
            end
            list_cnt = list_cnt + CntW'(1);
          end
        end
      end
    end

    // Next path state; after a failure only the failed flag matters.
    head_d   = e_head;
    run_d    = e_run;
    moves_d  = e_moves;
    cells_d  = e_cells;
    items_d  = e_items;
    turns_d  = e_turns;
    failed_d = e_failed;
    if (!e_failed) begin
      if (fail) begin
        failed_d = 1'b1;
      end else if (last_of_path_i) begin
        head_d  = start_head_q;
        run_d   = '0;
        moves_d = '0;
        cells_d = '0;
        items_d = '0;
        turns_d = '0;
      end else begin
        head_d  = change ? new_head : e_head;
        run_d   = run_mid;
        moves_d = m;
        cells_d = cells_fin;
        items_d = items_nx;
        turns_d = t;
      end
    end
  end

  // Result buffer: load a fresh list on a transfer, else advance one entry per pop.
  always_comb begin
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    if (in_xfer) begin
      pend_d     = list;
      pend_cnt_d = list_cnt;
    end else if (pop) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        pend_d[i] = pend_q[i+1];
      end
      pend_cnt_d = pend_cnt_q - CntW'(1);
    end
  end

  // Output register: take the head entry whenever the register is free.
  always_comb begin
    out_d       = out_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q;
    if (pop) begin
      out_d       = pend_q[0];
      out_last_d  = (pend_cnt_q == CntW'(1));
      out_valid_d = 1'b1;
    end else if (out_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_speed_q  <= RunSpeedReset;
      start_head_q <= StartHeadReset;
      head_q       <= StartHeadReset;
      run_q        <= '0;
      moves_q      <= '0;
      cells_q      <= '0;
      items_q      <= '0;
      turns_q      <= '0;
      failed_q     <= 1'b0;
      pend_cnt_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CfgRunSpeed:     run_speed_q  <= cfg_data_i[SpeedW-1:0];
          CfgStartHeading: start_head_q <= cfg_data_i[HeadW-1:0];
          default:         ;
        endcase
      end
      if (in_xfer) begin
        head_q   <= head_d;
        run_q    <= run_d;
        moves_q  <= moves_d;
        cells_q  <= cells_d;
        items_q  <= items_d;
        turns_q  <= turns_d;
        failed_q <= failed_d;
      end
      pend_cnt_q  <= pend_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign move_kind_o   = out_q.kind;
  assign cell_count_o  = out_q.cells;
  assign speed_o       = out_q.speed;
  assign move_index_o  = out_q.idx;
  assign status_o      = out_q.status;
  assign turn_total_o  = out_q.turns;
  assign last_result_o = out_last_q;

  // Buffer never holds more than one item's worth of commands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_cnt_q <= CntW'(MaxResults))
    else $error("result buffer count out of range");

  // Move store count never passes its limit, and turns are a subset of moves.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (moves_q <= MovesW'(MaxMoves)) && (TurnsW'(turns_q) <= TurnsW'(moves_q)))
    else $error("move or turn count out of range");

  // Only DONE carries a status; only FORWARD carries cells and speed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind != KindDone)) |-> (out_q.status == StatusOk))
    else $error("status on a non-done command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_q.kind != KindFwd)) |-> ((out_q.cells == '0) && (out_q.speed == '0)))
    else $error("cells or speed on a non-forward command");

  // An accepted item on a failed path without a path start adds no commands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && failed_q && !first_of_path_i) |=> (pend_cnt_q == '0))
    else $error("failed path produced a command");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the heading path encoder: directed, store-full and random runs.
module tb;
  import hprle_pkg::*;

  // Give up after this many cycles with no transfer on either channel.
  localparam int IdleLimit = 1000;

  typedef struct packed {
    move_t cmd;
    logic  last;
  } move_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                cfg_we = 1'b0;
  cfg_idx_e            cfg_index = CfgRunSpeed;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic                in_valid = 1'b0;
  logic                in_stall_o;
  logic [HeadingW-1:0] heading = '0;
  logic                first_mark = 1'b0;
  logic                last_mark = 1'b0;

  logic                out_valid_o;
  logic                out_stall = 1'b0;
  logic [KindW-1:0]    move_kind_o;
  logic [CellW-1:0]    cell_count_o;
  logic [SpeedW-1:0]   speed_o;
  logic [IdxW-1:0]     move_index_o;
  logic [StatusW-1:0]  status_o;
  logic [TurnsW-1:0]   turn_total_o;
  logic                last_result_o;

  heading_path_run_length_encoder u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall_o),
    .heading_i      (heading),
    .first_of_path_i(first_mark),
    .last_of_path_i (last_mark),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall),
    .move_kind_o    (move_kind_o),
    .cell_count_o   (cell_count_o),
    .speed_o        (speed_o),
    .move_index_o   (move_index_o),
    .status_o       (status_o),
    .turn_total_o   (turn_total_o),
    .last_result_o  (last_result_o)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Path encoder prediction: own copy of the registers and of the path state.
  // ---------------------------------------------------------------------------
  logic [SpeedW-1:0] cfg_speed = RunSpeedReset;
  logic [HeadW-1:0]  cfg_start = StartHeadReset;

  logic [HeadW-1:0]  head_now;
  logic [CellW-1:0]  run_cells;
  logic [6:0]        moves_done;
  logic [CellW-1:0]  cells_done;
  logic [7:0]        items_done;
  logic [TurnsW-1:0] turns_done;
  logic              path_dead;

  move_t     item_moves[$];     // commands of the item being predicted
  move_rec_t pending_moves[$];  // commands predicted but not yet seen on the output

  int errors = 0;
  int items_used = 0;
  int moves_checked = 0;
  int paths_closed = 0;
  int overflow_seen = 0;
  int mismatch_seen = 0;

  function automatic void restart_path();
    head_now   = cfg_start;
    run_cells  = '0;
    moves_done = '0;
    cells_done = '0;
    items_done = '0;
    turns_done = '0;
    path_dead  = 1'b0;
  endfunction

  // Store one command; a full move store turns it into an overflow DONE and kills the path.
  function automatic bit store_move(move_kind_e kind, logic [CellW-1:0] cells,
                                    logic [SpeedW-1:0] spd, status_e st);
    move_t m;
    m = '0;
    m.idx = moves_done[IdxW-1:0];
    if (moves_done >= MaxMoves) begin
      m.kind   = KindDone;
      m.status = StatusOverflow;
      m.turns  = turns_done;
      item_moves.push_back(m);
      path_dead = 1'b1;
      return 1'b0;
    end
    m.kind   = kind;
    m.cells  = cells;
    m.speed  = spd;
    m.status = st;
    if (kind == KindDone) m.turns = turns_done;
    item_moves.push_back(m);
    moves_done = moves_done + 7'd1;
    return 1'b1;
  endfunction

  function automatic bit close_run();
    logic [CellW-1:0] n;
    n = run_cells;
    if (n == 0) return 1'b1;
    run_cells  = '0;
    cells_done = cells_done + n;
    return store_move(KindFwd, n, cfg_speed, StatusOk);
  endfunction

  // Work out the commands of one accepted item and queue them; returns 0 for an ignored item.
  function automatic bit encode_heading(logic [HeadingW-1:0] hd, logic fp, logic lp);
    logic [HeadW-1:0] diff;
    move_kind_e       turn;
    status_e          st;
    move_t            over;
    bit               ok;
    item_moves.delete();
    if (fp) restart_path();
    if (path_dead) return 1'b0;
    if (items_done >= MaxPathCells) begin
      // path too long: one overflow DONE, item not used
      over        = '0;
      over.kind   = KindDone;
      over.status = StatusOverflow;
      over.idx    = moves_done[IdxW-1:0];
      over.turns  = turns_done;
      item_moves.push_back(over);
      path_dead = 1'b1;
    end else begin
      items_done = items_done + 8'd1;
      ok = 1'b1;
      if (hd < 4) begin
        if (hd[HeadW-1:0] == head_now) begin
          run_cells = run_cells + 8'd1;
        end else begin
          diff = hd[HeadW-1:0] - head_now;
          turn = (diff == 2'd1) ? KindRight : (diff == 2'd3) ? KindLeft : KindUturn;
          ok = close_run();
          if (ok) ok = store_move(turn, '0, '0, StatusOk);
          if (ok) begin
            turns_done = turns_done + 7'd1;
            head_now   = hd[HeadW-1:0];
            run_cells  = 8'd1;
          end
        end
      end
      if (ok && lp) begin
        ok = close_run();
        if (ok) begin
          st = (cells_done != items_done) ? StatusMismatch : StatusOk;
          if (store_move(KindDone, '0, '0, st)) restart_path();
        end
      end
    end
    foreach (item_moves[i]) pending_moves.push_back('{item_moves[i], i == item_moves.size() - 1});
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: bursts of transfers with random gaps in between.
  // ---------------------------------------------------------------------------
  int burst_left = 0;

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // mostly short bursts, now and then a long unbroken stretch
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Present one item, hold it until the transfer, then predict its commands.
  task automatic send_item(logic [HeadingW-1:0] hd, logic fp, logic lp);
    pace();
    in_valid   <= 1'b1;
    heading    <= hd;
    first_mark <= fp;
    last_mark  <= lp;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    if (encode_heading(hd, fp, lp)) items_used++;
  endtask

  // Drop valid and wait until every predicted command has come out, plus a short tail.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers back to back; only called while the block is idle.
  task automatic program_regs(logic [SpeedW-1:0] spd, logic [HeadW-1:0] hd);
    logic [CfgDataW-1:0] word;
    word = {14'($urandom), hd};  // upper bits are noise, only the low two count
    cfg_we    <= 1'b1;
    cfg_index <= CfgRunSpeed;
    cfg_data  <= spd;
    @(posedge clk);
    cfg_speed = spd;
    cfg_index <= CfgStartHeading;
    cfg_data  <= word;
    @(posedge clk);
    cfg_start = hd;
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall pattern switches between calm, sparse and bursty modes.
  // ---------------------------------------------------------------------------
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_hold = 0;

  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode      = $urandom_range(0, 2);
      rx_mode_left = $urandom_range(16, 96);
    end else begin
      rx_mode_left--;
    end
    case (rx_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold == 0 && $urandom_range(0, 5) == 0) rx_hold = $urandom_range(1, 8);
        out_stall <= (rx_hold != 0);
        if (rx_hold != 0) rx_hold--;
      end
    endcase
  end

  task automatic report_error(string msg);
    $display("%0t ns: mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s got %0d want %0d (command %0d)", name, got, want, moves_checked));
  endtask

  // Compare every output transfer with the oldest prediction.
  always @(posedge clk) begin : check_out
    move_rec_t want;
    if (rst_n && out_valid_o === 1'b1 && out_stall == 1'b0) begin
      moves_checked++;
      if (pending_moves.size() == 0) begin
        report_error($sformatf("command with no prediction: kind %0d index %0d",
                               move_kind_o, move_index_o));
      end else begin
        want = pending_moves.pop_front();
        check_field("move_kind", move_kind_o, want.cmd.kind);
        check_field("cell_count", cell_count_o, want.cmd.cells);
        check_field("speed", speed_o, want.cmd.speed);
        check_field("move_index", move_index_o, want.cmd.idx);
        check_field("status", status_o, want.cmd.status);
        check_field("turn_total", turn_total_o, want.cmd.turns);
        check_field("last_result", last_result_o, want.last);
      end
      if (move_kind_o == KindDone) begin
        if (status_o == StatusOverflow) overflow_seen++;
        else paths_closed++;
        if (status_o == StatusMismatch) mismatch_seen++;
      end
    end
  end

  // Watchdog: count cycles without any transfer.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles", IdleLimit);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every turn kind, invalid headings, implicit and explicit path starts, both marks at once.
  // Runs on the reset register values.
  task automatic test_directed();
    send_item(3'd0, 1'b1, 1'b0);  // straight from the start heading
    send_item(3'd0, 1'b0, 1'b0);
    send_item(3'd1, 1'b0, 1'b0);  // forward 2, right
    send_item(3'd3, 1'b0, 1'b0);  // forward 1, about turn
    send_item(3'd2, 1'b0, 1'b0);  // forward 1, left
    send_item(3'd5, 1'b0, 1'b0);  // invalid heading: counted, no cell
    send_item(3'd2, 1'b0, 1'b0);
    send_item(3'd4, 1'b0, 1'b0);
    send_item(3'd0, 1'b0, 1'b1);  // four commands: forward, about turn, forward, done
    send_item(3'd1, 1'b0, 1'b1);  // no first mark: starts fresh after done
    send_item(3'd3, 1'b1, 1'b1);  // both marks on one item
    send_item(3'd6, 1'b1, 1'b1);  // lone invalid heading: cell total mismatch
    send_item(3'd7, 1'b1, 1'b0);  // path abandoned by a new first mark
    send_item(3'd2, 1'b0, 1'b0);
    send_item(3'd2, 1'b1, 1'b0);
    send_item(3'd2, 1'b0, 1'b0);
    send_item(3'd2, 1'b0, 1'b1);
    settle();
  endtask

  // Fill the move store so that it runs out on the closing done or on the closing forward.
  // Relies on the reset start heading.
  task automatic test_move_store_full();
    int k;
    int j;
    int turns;
    logic [HeadW-1:0] h;
    for (k = 0; k < 2; k++) begin
      h     = (k == 1) ? 2'd0 : 2'd1;  // heading 0 opens with a straight, not a turn
      turns = (k == 1) ? 32 : 31;
      send_item({1'b0, h}, 1'b1, 1'b0);
      for (j = 0; j < turns; j++) begin
        h = h + 2'($urandom_range(1, 3));
        send_item({1'b0, h}, 1'b0, 1'b0);
      end
      send_item({1'b0, h}, 1'b0, 1'b1);
      // ignored once the path has failed
      send_item(3'($urandom_range(0, 7)), 1'b0, 1'b0);
      send_item(3'($urandom_range(0, 7)), 1'b0, 1'b1);
    end
    settle();
  endtask

  // Random paths in phases, each with its own register setting; a phase may end mid path,
  // so a new start heading can land inside an open path.
  task automatic test_random_paths();
    int p;
    int target;
    int path_left;
    int r;
    logic [HeadW-1:0]    prev;
    logic [HeadingW-1:0] hd;
    logic                fp;
    logic                lp;
    logic [SpeedW-1:0]   spd;
    logic [HeadW-1:0]    start;
    path_left = 0;
    prev = '0;
    for (p = 0; p < 4; p++) begin
      case (p)
        0:       begin spd = 16'd0;           start = 2'd3; end
        1:       begin spd = 16'hFFFF;        start = 2'd1; end
        2:       begin spd = 16'($urandom);   start = 2'd2; end
        default: begin spd = 16'($urandom);   start = 2'd0; end
      endcase
      settle();
      program_regs(spd, start);
      target = items_used + 8;
      while (items_used < target) begin
        if (path_left == 0) begin
          path_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 12);
          fp = ($urandom_range(0, 7) != 0);
        end else begin
          fp = 1'b0;
        end
        r = $urandom_range(0, 19);
        if (r < 8) hd = {1'b0, prev};
        else if (r < 18) hd = 3'($urandom_range(0, 3));
        else hd = 3'($urandom_range(4, 7));
        if (hd < 4) prev = hd[HeadW-1:0];
        lp = (path_left == 1);
        // occasional broken framing
        if ($urandom_range(0, 24) == 0) fp = ~fp;
        if ($urandom_range(0, 24) == 0) lp = ~lp;
        path_left--;
        send_item(hd, fp, lp);
      end
    end
    settle();
  endtask

  initial begin
    restart_path();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_move_store_full();
    test_random_paths();

    // all commands are in; settle() above has already waited out the tail
    $display("ran %0d used headings, checked %0d commands over %0d closed paths",
             items_used, moves_checked, paths_closed);
    $display("saw %0d overflow results and %0d cell total mismatches",
             overflow_seen, mismatch_seen);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/hprle_pkg.sv
hdl/heading_path_run_length_encoder.sv
bench/tb.sv
